FILE: hdl/krl_pkg.sv
// shared types and constants for the keyed window rate limiter
// no dependencies
package krl_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // register indexes on the configuration port
    localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [1:0] REG_REQUEST_LIMIT  = 2'd1;
    localparam logic [1:0] REG_PENALTY_LENGTH = 2'd2;
    localparam logic [1:0] REG_PENALTY_LIMIT  = 2'd3;

    // verdict codes
    localparam logic [1:0] VERDICT_ALLOWED  = 2'd0;
    localparam logic [1:0] VERDICT_PENALIZED = 2'd1;
    localparam logic [1:0] VERDICT_EXCEEDED = 2'd2;

    typedef struct packed {
        logic        key_present;
        logic [63:0] key_id;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic [1:0] verdict;
        logic       permanent_flag;
        logic       table_full;
    } t_res;

    typedef struct packed {
        logic [16:0] window_length;
        logic [15:0] request_limit;
        logic [16:0] penalty_length;
        logic [7:0]  penalty_limit;
    } t_cfg;

    // one table entry
    typedef struct packed {
        logic [63:0] key;
        logic [15:0] req_count;
        logic [31:0] win_origin;
        logic [7:0]  pen_count;
        logic [31:0] pen_end;
    } t_entry;

endpackage

FILE: hdl/krl_front.sv
// front end: accepts request transactions into a two-deep queue
// depends on krl_pkg
module krl_front
    import krl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_out_valid,
    output t_req o_out_req,
    input  logic i_out_ready
);

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign busy        = (r_cnt == 2'd2);
    assign push        = start && !busy;
    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_req   = r_q[r_rd_ptr];

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_req;
        end
    end

endmodule

FILE: hdl/krl_back.sv
// back end: key search over the entry table and read-modify-write of one entry
// depends on krl_pkg
module krl_back
    import krl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    input  t_req i_in_req,
    output logic o_in_ready,
    output logic o_res_valid,
    output t_res o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_EVAL
    } t_state;

    t_state           r_state;
    t_req             r_req;
    t_entry           r_ent;
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_entry_count;
    logic             r_res_valid;
    t_res             r_res;

    t_entry           mem [ENTRIES];
    t_entry           r_rd_data;
    logic             rd_en;
    logic             wr_en;
    t_entry           wr_data;

    // evaluation of one entry
    logic [31:0] pen_diff;
    logic        pen_running;
    logic [31:0] age;
    logic        restart;
    logic [15:0] cnt_eff;
    logic        exceeded;
    logic [7:0]  pen_next;

    assign pen_diff    = r_ent.pen_end - r_req.now_seconds;
    assign pen_running = (pen_diff != 32'd0) && !pen_diff[31];
    assign age         = r_req.now_seconds - r_ent.win_origin;
    assign restart     = (age >= {15'd0, i_cfg.window_length});
    assign cnt_eff     = restart ? 16'd0 : r_ent.req_count;
    assign exceeded    = (cnt_eff >= i_cfg.request_limit);
    assign pen_next    = (r_ent.pen_count == 8'hFF) ? r_ent.pen_count
                                                    : r_ent.pen_count + 8'd1;

    assign rd_en = (r_state == ST_SEARCH) && (r_idx != r_entry_count);
    assign wr_en = (r_state == ST_EVAL) && !pen_running;

    // updated entry
    always_comb begin
        wr_data = r_ent;
        if (exceeded) begin
            wr_data.pen_count  = pen_next;
            wr_data.pen_end    = r_req.now_seconds + {15'd0, i_cfg.penalty_length};
            wr_data.req_count  = 16'd0;
            wr_data.win_origin = r_req.now_seconds;
        end else begin
            wr_data.req_count = cnt_eff + 16'd1;
            if (restart) begin
                wr_data.win_origin = r_req.now_seconds;
            end
        end
    end

    // entry table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_slot] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // sequencer: search, then evaluate and write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_idx         <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_req;
                        r_idx <= '0;
                        if (!i_in_req.key_present) begin
                            r_res_valid <= 1'b1;
                            r_res       <= '{VERDICT_ALLOWED, 1'b0, 1'b0};
                        end else begin
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (r_idx != r_entry_count) begin
                        r_state <= ST_CHECK;
                    end else if (r_entry_count == CNT_W'(ENTRIES)) begin
                        r_res_valid <= 1'b1;
                        r_res       <= '{VERDICT_ALLOWED, 1'b0, 1'b1};
                        r_state     <= ST_IDLE;
                    end else begin
                        // new key takes the next free entry
                        r_ent.key        <= r_req.key_id;
                        r_ent.req_count  <= 16'd0;
                        r_ent.win_origin <= r_req.now_seconds;
                        r_ent.pen_count  <= 8'd0;
                        r_ent.pen_end    <= r_req.now_seconds;
                        r_slot           <= r_entry_count[IDX_W-1:0];
                        r_entry_count    <= r_entry_count + CNT_W'(1);
                        r_state          <= ST_EVAL;
                    end
                end
                ST_CHECK: begin
                    if (r_rd_data.key == r_req.key_id) begin
                        r_ent   <= r_rd_data;
                        r_slot  <= r_idx[IDX_W-1:0];
                        r_state <= ST_EVAL;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= ST_SEARCH;
                    end
                end
                ST_EVAL: begin
                    r_res_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                    if (pen_running) begin
                        r_res <= '{VERDICT_PENALIZED, 1'b0, 1'b0};
                    end else if (exceeded) begin
                        r_res <= '{VERDICT_EXCEEDED,
                                   (pen_next >= i_cfg.penalty_limit), 1'b0};
                    end else begin
                        r_res <= '{VERDICT_ALLOWED, 1'b0, 1'b0};
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/keyed_window_rate_limiter.sv
// top level: configuration registers, request queue and table engine
// depends on krl_pkg, krl_front, krl_back
//
// A request transaction is taken when start is high and busy is low; up to two
// requests queue ahead of the table engine. Each request yields exactly one
// result, shown on o_res for one cycle with o_res_valid, in request order; the
// receiver cannot stall it. A request without a key is answered straight from
// the idle state. A keyed request searches the stored keys one at a time
// through the single read port of the entry table, reading each stored key in
// the search state and comparing it in the check state. A found key or a new
// key goes on to the evaluate state, which writes the entry back unless a
// penalty is running; a request that finds the table full is answered from
// the search state. Entries are never evicted; the table holds 1024 keys and
// needs no clearing after reset.
module keyed_window_rate_limiter
    import krl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_req        i_req,
    output logic        busy,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    logic cfg_wr;
    logic q_valid;
    t_req q_req;
    logic q_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length  <= 17'd60;
            r_cfg.request_limit  <= 16'd100;
            r_cfg.penalty_length <= 17'd300;
            r_cfg.penalty_limit  <= 8'd5;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WINDOW_LENGTH:  r_cfg.window_length  <= pwdata[16:0];
                REG_REQUEST_LIMIT:  r_cfg.request_limit  <= pwdata[15:0];
                REG_PENALTY_LENGTH: r_cfg.penalty_length <= pwdata[16:0];
                REG_PENALTY_LIMIT:  r_cfg.penalty_limit  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_WINDOW_LENGTH:  prdata = {15'd0, r_cfg.window_length};
            REG_REQUEST_LIMIT:  prdata = {16'd0, r_cfg.request_limit};
            REG_PENALTY_LENGTH: prdata = {15'd0, r_cfg.penalty_length};
            REG_PENALTY_LIMIT:  prdata = {24'd0, r_cfg.penalty_limit};
            default:            prdata = 32'd0;
        endcase
    end

    krl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_out_valid (q_valid),
        .o_out_req   (q_req),
        .i_out_ready (q_ready)
    );

    krl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (q_valid),
        .i_in_req    (q_req),
        .o_in_ready  (q_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.verdict != 2'd3)
        else $error("undefined verdict code");
    a_perm_only_exceeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.permanent_flag) |-> o_res.verdict == VERDICT_EXCEEDED)
        else $error("permanent flag without exceeded verdict");
    a_full_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.table_full) |-> o_res.verdict == VERDICT_ALLOWED)
        else $error("table full result not allowed");
`endif

endmodule

FILE: test/krl_checker.sv
// checker for the keyed window rate limiter: predicts each result and compares it
// depends on krl_pkg; watches the request, result and configuration ports
`timescale 1ns / 100ps
module krl_checker
    import krl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_req        i_req,
    input  logic        i_res_valid,
    input  t_res        i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_entries,
    output int          o_exceeded,
    output int          o_results
);

    // mirrored table and configuration
    logic [63:0] key_tab   [ENTRIES];
    logic [15:0] req_tab   [ENTRIES];
    logic [31:0] win_tab   [ENTRIES];
    logic [7:0]  pcnt_tab  [ENTRIES];
    logic [31:0] pend_tab  [ENTRIES];
    int          stored;
    t_cfg        cfg;
    t_res        expected_verdicts[$];

    // police one request against the mirrored table
    function automatic t_res police(t_req rq);
        t_res        r;
        int          slot;
        logic [31:0] diff;
        r    = '0;
        slot = -1;
        if (!rq.key_present) return r;
        for (int i = 0; i < stored; i++) begin
            if (key_tab[i] == rq.key_id) begin
                slot = i;
                break;
            end
        end
        if (slot < 0) begin
            if (stored >= ENTRIES) begin
                r.table_full = 1'b1;
                return r;
            end
            slot           = stored;
            key_tab[slot]  = rq.key_id;
            req_tab[slot]  = '0;
            win_tab[slot]  = rq.now_seconds;
            pcnt_tab[slot] = '0;
            pend_tab[slot] = rq.now_seconds;
            stored++;
        end
        diff = pend_tab[slot] - rq.now_seconds;
        if (diff != 0 && !diff[31]) begin
            r.verdict = VERDICT_PENALIZED;
            return r;
        end
        if (32'(rq.now_seconds - win_tab[slot]) >= {15'd0, cfg.window_length}) begin
            win_tab[slot] = rq.now_seconds;
            req_tab[slot] = '0;
        end
        if (req_tab[slot] >= cfg.request_limit) begin
            if (pcnt_tab[slot] != 8'hFF) pcnt_tab[slot]++;
            pend_tab[slot]   = rq.now_seconds + {15'd0, cfg.penalty_length};
            req_tab[slot]    = '0;
            win_tab[slot]    = rq.now_seconds;
            r.verdict        = VERDICT_EXCEEDED;
            r.permanent_flag = (pcnt_tab[slot] >= cfg.penalty_limit);
            return r;
        end
        req_tab[slot]++;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            stored = 0;
            cfg    = '{window_length: 17'd60, request_limit: 16'd100,
                       penalty_length: 17'd300, penalty_limit: 8'd5};
            expected_verdicts.delete();
            o_fail_count = 0;
            o_exceeded   = 0;
            o_results    = 0;
        end else begin
            // compare a result transaction with the oldest prediction
            if (i_res_valid) begin
                o_results++;
                if (expected_verdicts.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result %p", $realtime, i_res);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (want.verdict == VERDICT_EXCEEDED) o_exceeded++;
                    if (i_res.verdict !== want.verdict
                        || i_res.permanent_flag !== want.permanent_flag
                        || i_res.table_full !== want.table_full) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: result mismatch expected %p actual %p",
                                     $realtime, want, i_res);
                    end
                end
            end
            // request transaction
            if (i_start && !i_busy) expected_verdicts.push_back(police(i_req));
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_WINDOW_LENGTH:  cfg.window_length  = i_pwdata[16:0];
                    REG_REQUEST_LIMIT:  cfg.request_limit  = i_pwdata[15:0];
                    REG_PENALTY_LENGTH: cfg.penalty_length = i_pwdata[16:0];
                    REG_PENALTY_LIMIT:  cfg.penalty_limit  = i_pwdata[7:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_verdicts.size();
        o_entries = stored;
    end

endmodule

FILE: test/keyed_window_rate_limiter_test.sv
// testbench top for the keyed window rate limiter: stimulus, configuration and verdict
// depends on krl_pkg, keyed_window_rate_limiter and krl_checker
`timescale 1ns / 100ps
module keyed_window_rate_limiter_test;
    import krl_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_req        req;
    logic        busy;
    logic        res_valid;
    t_res        res;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, entries, exceeded, results;

    logic [63:0] key_pool[8];
    logic [31:0] clock_now;
    int          sent;

    keyed_window_rate_limiter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(req), .busy(busy),
        .o_res_valid(res_valid), .o_res(res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    krl_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_req(req),
        .i_res_valid(res_valid), .i_res(res), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_entries(entries),
        .o_exceeded(exceeded), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // one request transaction, entered and left at a falling edge
    task automatic send_request(logic present, logic [63:0] key, logic [31:0] now);
        int gap;
        start = 1'b1;
        req   = '{key_present: present, key_id: key, now_seconds: now};
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        sent++;
        gap = $urandom_range(0, 99);
        gap = (gap < 65) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            start = 1'b0;
            req   = t_req'(97'({$urandom, $urandom, $urandom, $urandom}));
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // write all registers once the block has drained
    task automatic set_policy(logic [31:0] wlen, logic [31:0] rlim,
                              logic [31:0] plen, logic [31:0] plim);
        logic [31:0] vals[4];
        vals  = '{wlen, rlim, plen, plim};
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        for (int i = 0; i < 4; i++) begin
            psel    = 1'b1;
            pwrite  = 1'b1;
            penable = 1'b0;
            paddr   = 4'(i * 4);
            pwdata  = vals[i];
            @(negedge i_clk);
            penable = 1'b1;
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    // mostly pooled keys on a slowly moving clock, with noise
    task automatic random_traffic(int n);
        int          pick;
        logic [31:0] now;
        logic [63:0] key;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            clock_now += (pick < 3) ? $urandom : $urandom_range(0, 2);
            now = clock_now;
            if ($urandom_range(0, 19) == 0) now = clock_now - $urandom_range(1, 30);
            key = key_pool[$urandom_range(0, 7)];
            if (pick >= 95) key = {$urandom, $urandom};
            send_request(pick != 50 && pick != 51 && pick != 52, key, now);
        end
    endtask

    initial begin
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sent    = 0;
        i_rst_n = 1'b0;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '1;
        key_pool[1] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes, no key, window restart, time wrap
        send_request(1'b0, '1, '1);
        send_request(1'b1, '0, '0);
        send_request(1'b1, '1, '1);
        send_request(1'b1, '1, 32'd0);
        send_request(1'b1, '0, 32'd59);
        send_request(1'b1, '0, 32'd60);
        send_request(1'b0, '0, '0);
        send_request(1'b1, 64'h8000_0000_0000_0001, 32'h8000_0000);

        // reset policy
        clock_now = $urandom;
        random_traffic(40);

        // tight limits so penalties come often
        set_policy(32'd10, 32'd3, 32'd20, 32'd2);
        random_traffic(40);

        // zero everything: every request exceeds, penalty count saturates
        set_policy(32'd0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 262; i++) send_request(1'b1, key_pool[2], clock_now);
        random_traffic(20);

        // widest values, upper bits above each field width set
        set_policy('1, '1, '1, '1);
        random_traffic(20);

        // one request per window around the time wrap
        set_policy(32'd1, 32'd1, 32'd5, 32'd1);
        clock_now = 32'hFFFF_FFF0;
        random_traffic(30);

        // fill the table, then overflow it
        set_policy(32'd60, 32'd100, 32'd300, 32'd5);
        while (entries < ENTRIES) send_request(1'b1, {$urandom, $urandom}, clock_now);
        for (int i = 0; i < 6; i++) send_request(1'b1, {$urandom, $urandom}, clock_now);
        for (int i = 0; i < 6; i++) send_request(1'b1, key_pool[i], clock_now);

        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d exceeded, table of %0d keys",
                 sent, results, exceeded, entries);
        $display("five register settings covered, including zero, maximum and time wrap");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
